// ===== hw/rtl/btda_pkg.sv =====
// ----------------------------------------------------------------------------
// btda_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the value width, digit count, command codes, FSM and cell control.
// ----------------------------------------------------------------------------
package btda_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int NUM_DIGITS  = 10;
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    CMD_UNSIGNED = 2'd0,
    CMD_SIGNED   = 2'd1,
    CMD_FIXED    = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Control broadcast to every digit cell
  typedef struct packed {
    logic clear;   // load zero
    logic dabble;  // add-3 adjust and shift one bit in from below
    logic dshift;  // move whole digits one cell up
  } cell_ctl_t;

endpackage

// ===== hw/rtl/btda_cell.sv =====
// ----------------------------------------------------------------------------
// btda_cell: one BCD digit of the shift-add-3 chain
// Adjusts and shifts one bit per cycle during conversion, then passes whole
// digits up the chain during character output.
// ----------------------------------------------------------------------------
module btda_cell (
  input  logic                  clk,
  input  btda_pkg::cell_ctl_t   ctl,
  input  logic                  cin,
  input  logic [3:0]            din,
  output logic                  cout,
  output logic [3:0]            dout
);
  import btda_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // Add three when the digit would reach ten after the shift
  assign adj  = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign cout = adj[3];
  assign dout = digit_r;

  // Select the next digit
  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], cin};
    end else if (ctl.dshift) begin
      digit_nxt = din;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Sequence: after the accepting edge the conversion shifts all VALUE_BITS bits in,
//   then come an optional minus sign and a digit-shift step for each of the ten
//   cells; results are registered, each in the cycle after its step, at most one character per cycle.
// Busy from acceptance until the last digit step, and no new item is taken before then,
//   as the bit-serial pass runs through the ten-cell digit chain.
// Unused command and a zero count in fixed mode finish at once. Synchronous active-low reset
//   clears the FSM and the strobe; the receiver cannot stall the output.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: binary to ASCII decimal converter
// Converts a value with a chain of BCD cells and emits characters MSB first.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_digit_count,
  output logic        out_strobe,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import btda_pkg::*;

  state_t                   state_r, state_nxt;
  logic [VALUE_BITS-1:0]    mag_r, mag_nxt;
  logic [BIT_CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [DIGIT_IDX_W-1:0]   idx_r, idx_nxt;
  logic [DIGIT_IDX_W-1:0]   skip_r, skip_nxt;
  logic                     fixed_r, fixed_nxt;
  logic                     neg_r, neg_nxt;
  logic                     seen_r, seen_nxt;
  logic                     strobe_r, strobe_nxt;
  logic [7:0]               char_r, char_nxt;
  logic                     last_r, last_nxt;

  logic                     accept;
  logic [VALUE_BITS-1:0]    val_ext;
  logic [3:0]               cnt_sat;
  cell_ctl_t                ctl;
  logic [3:0]               dig [NUM_DIGITS];
  logic                     lo_bit [NUM_DIGITS];
  logic [3:0]               top_dig;
  logic                     top_carry;
  logic                     emit_now;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign val_ext = VALUE_BITS'(in_value);
  assign cnt_sat = (in_digit_count > 4'(NUM_DIGITS)) ? 4'(NUM_DIGITS) : in_digit_count;
  assign top_dig = dig[NUM_DIGITS-1];

  // Digit chain: bits enter at the bottom cell, digits leave at the top
  assign lo_bit[0] = mag_r[VALUE_BITS-1];
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == NUM_DIGITS - 1) begin : g_top
      btda_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .cin  (lo_bit[i]),
        .din  (dig[i-1]),
        .cout (top_carry),
        .dout (dig[i])
      );
    end else if (i == 0) begin : g_bot
      btda_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .cin  (lo_bit[i]),
        .din  (4'd0),
        .cout (lo_bit[i+1]),
        .dout (dig[i])
      );
    end else begin : g_mid
      btda_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .cin  (lo_bit[i]),
        .din  (dig[i-1]),
        .cout (lo_bit[i+1]),
        .dout (dig[i])
      );
    end
  end

  // Emit a digit once past the leading zeros or the fixed-width skip
  always_comb begin
    if (fixed_r) begin
      emit_now = (idx_r >= skip_r);
    end else begin
      emit_now = seen_r || (top_dig != 4'd0) ||
                 (idx_r == DIGIT_IDX_W'(NUM_DIGITS - 1));
    end
  end

  // Sequence the conversion and the character output
  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    bit_cnt_nxt = bit_cnt_r;
    idx_nxt     = idx_r;
    skip_nxt    = skip_r;
    fixed_nxt   = fixed_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    strobe_nxt  = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    ctl         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.clear   = 1'b1;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS - 1);
          idx_nxt     = '0;
          seen_nxt    = 1'b0;
          skip_nxt    = DIGIT_IDX_W'(4'(NUM_DIGITS) - cnt_sat);
          mag_nxt     = val_ext;
          neg_nxt     = 1'b0;
          fixed_nxt   = 1'b0;
          unique case (in_command)
            CMD_UNSIGNED: state_nxt = ST_CONV;
            CMD_SIGNED: begin
              state_nxt = ST_CONV;
              if (val_ext[VALUE_BITS-1]) begin
                neg_nxt = 1'b1;
                mag_nxt = ~val_ext + VALUE_BITS'(1);
              end
            end
            CMD_FIXED: begin
              fixed_nxt = 1'b1;
              if (cnt_sat != 4'd0) begin
                state_nxt = ST_CONV;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        ctl.dabble  = 1'b1;
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = ASCII_MINUS;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.dshift = 1'b1;
        idx_nxt    = idx_r + DIGIT_IDX_W'(1);
        if (emit_now) begin
          seen_nxt   = 1'b1;
          strobe_nxt = 1'b1;
          char_nxt   = ASCII_ZERO + 8'(top_dig);
          last_nxt   = (idx_r == DIGIT_IDX_W'(NUM_DIGITS - 1));
        end
        if (idx_r == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Advance payload registers
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    idx_r     <= idx_nxt;
    skip_r    <= skip_nxt;
    fixed_r   <= fixed_nxt;
    neg_r     <= neg_nxt;
    seen_r    <= seen_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  // A beat only follows a sign or digit-output cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_SIGN || state_r == ST_EMIT))
    else $error("result beat without an output cycle");

  // Nothing follows the final beat of an item
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("beat after final character");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_character == ASCII_MINUS) |-> !out_last)
    else $error("minus sign marked last");

  // The top digit never carries out while a value shifts in
  a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> !top_carry)
    else $error("digit chain overflow");

endmodule
